[hw/rtl/btpc_pkg.sv]
// Shared types, constants and arithmetic helpers for the barometric compensation block.
package btpc_pkg;

    localparam int DivW   = 64;
    localparam int QDepth = 4;

    localparam logic [19:0] SkipMark   = 20'h80000;
    localparam logic [32:0] TempOffset = 33'd128000;
    localparam logic [20:0] PressBase  = 21'h100000;
    localparam logic [63:0] PressScale = 64'd3125;
    localparam logic [63:0] DivBias    = 64'h0000_8000_0000_0000;
    // floor(2^32 / 125): estimate of x/125 is low by at most one
    localparam logic [25:0] RecipM     = 26'd34359738;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SKIP = 2'd1,
        ST_ZDIV = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_TEMP = 2'd0,
        REG_PLO  = 2'd1,
        REG_PHI  = 2'd2,
        REG_P9   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic        kind;
        logic        skip;
        logic [19:0] rt;
        logic [19:0] rp;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic        skip;
        logic        zdiv;
        logic        neg;
        logic [19:0] rp;
        logic [31:0] centi;
        logic [31:0] milli;
    } t_side;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] plo;
        logic [63:0] phi;
        logic [15:0] p9;
    } t_cal;

    // 64 x 16 wrapping multiply, done as two partial products
    function automatic logic signed [48:0] part_lo(input logic [63:0] x,
                                                   input logic signed [15:0] c);
        return 49'($signed({1'b0, x[31:0]})) * 49'(c);
    endfunction

    function automatic logic [31:0] part_hi(input logic [63:0] x,
                                            input logic signed [15:0] c);
        return x[63:32] * {{16{c[15]}}, c};
    endfunction

    function automatic logic [63:0] join_parts(input logic signed [48:0] lo,
                                               input logic [31:0] hi);
        return {{15{lo[48]}}, lo} + {hi, 32'd0};
    endfunction

    function automatic logic [63:0] sext16(input logic [15:0] c);
        return {{48{c[15]}}, c};
    endfunction

endpackage

[hw/rtl/baro_temp_press_compensation.sv]
// Top level: calibration registers, front stage, request queue and compensation datapath.
//
//  Channel   Handshake              Payload
//  input     i_valid / o_stall      i_kind, i_raw_temperature, i_raw_pressure
//  output    o_valid / i_stall      o_status, o_temp_*, o_press_*
//  config    psel/penable/pready    paddr, pwdata, prdata (64-bit, regs at 8*i)
//
// One request per cycle sustained while the output is not stalled. Path: front register, queue,
// 13 temperature/divisor stages, a 64-stage divider (one quotient bit per stage), 9 scaling stages
// and the output register. A stalled output freezes the datapath; the queue keeps
// taking requests until it fills. Reset is synchronous and clears control and calibration registers.
module baro_temp_press_compensation #(
    parameter int QDEPTH = btpc_pkg::QDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_kind,
    input  logic [19:0]        i_raw_temperature,
    input  logic [19:0]        i_raw_pressure,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_temp_centi,
    output logic signed [31:0] o_temp_milli,
    output logic [31:0]        o_press_q24_8,
    output logic [14:0]        o_press_kpa,
    output logic [19:0]        o_press_micro_kpa,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    btpc_pkg::t_cal     r_cal;
    btpc_pkg::t_reg_idx reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = btpc_pkg::t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                btpc_pkg::REG_TEMP: r_cal.temp <= pwdata[47:0];
                btpc_pkg::REG_PLO:  r_cal.plo  <= pwdata;
                btpc_pkg::REG_PHI:  r_cal.phi  <= pwdata;
                btpc_pkg::REG_P9:   r_cal.p9   <= pwdata[15:0];
                default:            r_cal      <= r_cal;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            btpc_pkg::REG_TEMP: prdata = {16'd0, r_cal.temp};
            btpc_pkg::REG_PLO:  prdata = r_cal.plo;
            btpc_pkg::REG_PHI:  prdata = r_cal.phi;
            btpc_pkg::REG_P9:   prdata = {48'd0, r_cal.p9};
            default:            prdata = '0;
        endcase
    end

    logic            push, full, pop, empty;
    btpc_pkg::t_item f_item, q_item;

    btpc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_raw_temperature(i_raw_temperature),
        .i_raw_pressure   (i_raw_pressure),
        .o_push           (push),
        .o_item           (f_item),
        .i_full           (full)
    );

    btpc_queue #(
        .DEPTH(QDEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (f_item),
        .o_full (full),
        .i_pop  (pop),
        .o_item (q_item),
        .o_empty(empty)
    );

    btpc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cal            (r_cal),
        .i_empty          (empty),
        .i_item           (q_item),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_temp_centi     (o_temp_centi),
        .o_temp_milli     (o_temp_milli),
        .o_press_q24_8    (o_press_q24_8),
        .o_press_kpa      (o_press_kpa),
        .o_press_micro_kpa(o_press_micro_kpa)
    );

endmodule

[hw/rtl/btpc_front.sv]
// Input stage: takes requests, flags skipped measurements, hands them to the queue.
module btpc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_kind,
    input  logic [19:0]           i_raw_temperature,
    input  logic [19:0]           i_raw_pressure,
    output logic                  o_push,
    output btpc_pkg::t_item       o_item,
    input  logic                  i_full
);

    logic             r_vld;
    btpc_pkg::t_item  r_item;
    logic             accept;

    assign o_push  = r_vld && !i_full;
    assign o_stall = r_vld && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.kind <= i_kind;
            r_item.rt   <= i_raw_temperature;
            r_item.rp   <= i_raw_pressure;
            r_item.skip <= (i_raw_temperature == btpc_pkg::SkipMark) ||
                           (i_kind && (i_raw_pressure == btpc_pkg::SkipMark));
        end
    end

endmodule

[hw/rtl/btpc_queue.sv]
// Short request queue between the front and back parts.
module btpc_queue #(
    parameter int DEPTH = btpc_pkg::QDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  btpc_pkg::t_item  i_item,
    output logic             o_full,
    input  logic             i_pop,
    output btpc_pkg::t_item  o_item,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    btpc_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

[hw/rtl/btpc_div.sv]
// Pipelined unsigned 64-bit restoring divider, one quotient bit per stage.
module btpc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [63:0]       i_num,
    input  logic [63:0]       i_den,
    input  btpc_pkg::t_side   i_side,
    output logic              o_vld,
    output logic [63:0]       o_quo,
    output btpc_pkg::t_side   o_side
);

    localparam int NS = btpc_pkg::DivW;

    logic [NS-1:0]              r_vld;
    logic [NS-1:0][63:0]        r_rem;
    logic [NS-1:0][63:0]        r_quo;
    logic [NS-1:0][63:0]        r_den;
    btpc_pkg::t_side [NS-1:0]   r_side;

    logic [NS-1:0][63:0]        in_rem;
    logic [NS-1:0][63:0]        in_quo;
    logic [NS-1:0][63:0]        in_den;
    btpc_pkg::t_side [NS-1:0]   in_side;
    logic [NS-1:0]              in_vld;
    logic [NS-1:0][63:0]        n_rem;
    logic [NS-1:0][63:0]        n_quo;

    always_comb begin
        in_rem[0]  = '0;
        in_quo[0]  = i_num;
        in_den[0]  = i_den;
        in_side[0] = i_side;
        in_vld[0]  = i_vld;
        for (int s = 1; s < NS; s++) begin
            in_rem[s]  = r_rem[s-1];
            in_quo[s]  = r_quo[s-1];
            in_den[s]  = r_den[s-1];
            in_side[s] = r_side[s-1];
            in_vld[s]  = r_vld[s-1];
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [64:0] sh;
        logic [64:0] diff;
        assign sh   = {in_rem[s], in_quo[s][63]};
        assign diff = sh - {1'b0, in_den[s]};
        always_comb begin
            if (!diff[64]) begin
                n_rem[s] = diff[63:0];
                n_quo[s] = {in_quo[s][62:0], 1'b1};
            end else begin
                n_rem[s] = sh[63:0];
                n_quo[s] = {in_quo[s][62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_den  <= in_den;
            r_side <= in_side;
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_quo  = r_quo[NS-1];
    assign o_side = r_side[NS-1];

endmodule

[hw/rtl/btpc_back.sv]
// Compensation datapath: temperature, pressure divisor, divide, final scaling, output register.
module btpc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  btpc_pkg::t_cal     i_cal,
    input  logic               i_empty,
    input  btpc_pkg::t_item    i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_temp_centi,
    output logic signed [31:0] o_temp_milli,
    output logic [31:0]        o_press_q24_8,
    output logic [14:0]        o_press_kpa,
    output logic [19:0]        o_press_micro_kpa
);

    localparam int PreN  = 13;
    localparam int PostN = 9;

    logic en;

    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = i_cal.temp[15:0];
    assign t2 = i_cal.temp[31:16];
    assign t3 = i_cal.temp[47:32];
    assign p1 = i_cal.plo[15:0];
    assign p2 = i_cal.plo[31:16];
    assign p3 = i_cal.plo[47:32];
    assign p4 = i_cal.plo[63:48];
    assign p5 = i_cal.phi[15:0];
    assign p6 = i_cal.phi[31:16];
    assign p7 = i_cal.phi[47:32];
    assign p8 = i_cal.phi[63:48];
    assign p9 = i_cal.p9;

    logic                           r_out_vld;
    logic [PreN-1:0]                r_vld_pre;
    logic [PostN-1:0]               r_vld_post;
    btpc_pkg::t_side [PreN-1:0]     r_sd_pre;
    btpc_pkg::t_side [PreN-1:0]     n_sd_pre;
    btpc_pkg::t_side [PostN-1:0]    r_sd_post;

    assign en    = !r_out_vld || !i_stall;
    assign o_pop = en && !i_empty;

    // pre-divide stage registers
    logic [19:0]        r_rt;
    logic [31:0]        r_a1, r_dd, r_m1, r_m2, r_v1, r_m3, r_tf;
    logic signed [32:0] r_w1;
    logic [63:0]        r_wsq;
    logic signed [48:0] r_wp5, r_wp2;
    logic signed [48:0] r_lo6, r_lo3;
    logic [31:0]        r_hi6, r_hi3;
    logic [63:0]        r_wp5b, r_wp2b, r_wp5c, r_wp2c;
    logic [63:0]        r_x6, r_x3, r_w2, r_w1b;
    logic [47:0]        r_lo1;
    logic [31:0]        r_hi1;
    logic [63:0]        r_num0, r_dvs, r_num, r_mn, r_md;

    // pre-divide combinational values
    logic [31:0]        a1, dd, m1, m2, v1, sh12, m3, tf, c5, centi, milli;
    logic signed [32:0] w1;
    logic signed [65:0] sq;
    logic signed [48:0] wp5, wp2;
    logic [63:0]        w2, w1b, num0, dsum, dvs, num;
    logic [20:0]        pd;

    assign a1    = {15'd0, r_rt[19:3]} - {15'd0, t1, 1'b0};
    assign dd    = {16'd0, r_rt[19:4]} - {16'd0, t1};
    assign m1    = r_a1 * {{16{t2[15]}}, t2};
    assign m2    = r_dd * r_dd;
    assign v1    = $signed(r_m1) >>> 11;
    assign sh12  = $signed(r_m2) >>> 12;
    assign m3    = sh12 * {{16{t3[15]}}, t3};
    assign tf    = $signed(r_v1) + ($signed(r_m3) >>> 14);
    assign c5    = r_tf * 32'd5 + 32'd128;
    assign centi = $signed(c5) >>> 8;
    assign w1    = $signed({r_tf[31], r_tf} - btpc_pkg::TempOffset);
    assign milli = r_sd_pre[5].centi * 32'd10;
    assign sq    = 66'(r_w1) * 66'(r_w1);
    assign wp5   = 49'(r_w1) * 49'(p5);
    assign wp2   = 49'(r_w1) * 49'(p2);
    assign w2    = r_x6 + (r_wp5c << 17) + (btpc_pkg::sext16(p4) << 35);
    assign w1b   = ($signed(r_x3) >>> 8) + $signed(r_wp2c << 12) +
                   $signed(btpc_pkg::DivBias);
    assign pd    = btpc_pkg::PressBase - {1'b0, r_sd_pre[9].rp};
    assign num0  = ({43'd0, pd} << 31) - r_w2;
    assign dsum  = {16'd0, r_lo1} + {r_hi1, 32'd0};
    assign dvs   = $signed(dsum) >>> 33;
    assign num   = r_num0 * btpc_pkg::PressScale;

    always_comb begin
        n_sd_pre[0].kind  = i_item.kind;
        n_sd_pre[0].skip  = i_item.skip;
        n_sd_pre[0].zdiv  = 1'b0;
        n_sd_pre[0].neg   = 1'b0;
        n_sd_pre[0].rp    = i_item.rp;
        n_sd_pre[0].centi = '0;
        n_sd_pre[0].milli = '0;
        for (int i = 1; i < PreN; i++) begin
            n_sd_pre[i] = r_sd_pre[i-1];
        end
        n_sd_pre[5].centi = centi;
        n_sd_pre[6].milli = milli;
        n_sd_pre[12].zdiv = (r_dvs == '0);
        n_sd_pre[12].neg  = r_num[63] ^ r_dvs[63];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd_pre <= n_sd_pre;
            r_rt     <= i_item.rt;
            r_a1     <= a1;
            r_dd     <= dd;
            r_m1     <= m1;
            r_m2     <= m2;
            r_v1     <= v1;
            r_m3     <= m3;
            r_tf     <= tf;
            r_w1     <= w1;
            r_wsq    <= sq[63:0];
            r_wp5    <= wp5;
            r_wp2    <= wp2;
            r_lo6    <= btpc_pkg::part_lo(r_wsq, p6);
            r_hi6    <= btpc_pkg::part_hi(r_wsq, p6);
            r_lo3    <= btpc_pkg::part_lo(r_wsq, p3);
            r_hi3    <= btpc_pkg::part_hi(r_wsq, p3);
            r_wp5b   <= {{15{r_wp5[48]}}, r_wp5};
            r_wp2b   <= {{15{r_wp2[48]}}, r_wp2};
            r_x6     <= btpc_pkg::join_parts(r_lo6, r_hi6);
            r_x3     <= btpc_pkg::join_parts(r_lo3, r_hi3);
            r_wp5c   <= r_wp5b;
            r_wp2c   <= r_wp2b;
            r_w2     <= w2;
            r_w1b    <= w1b;
            r_lo1    <= 48'(r_w1b[31:0]) * 48'(p1);
            r_hi1    <= r_w1b[63:32] * {16'd0, p1};
            r_num0   <= num0;
            r_dvs    <= dvs;
            r_num    <= num;
            r_mn     <= r_num[63] ? (64'd0 - r_num) : r_num;
            r_md     <= r_dvs[63] ? (64'd0 - r_dvs) : r_dvs;
        end
    end

    // divide
    logic            div_vld;
    logic [63:0]     div_quo;
    btpc_pkg::t_side div_side;

    btpc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_vld_pre[PreN-1]),
        .i_num  (r_mn),
        .i_den  (r_md),
        .i_side (r_sd_pre[PreN-1]),
        .o_vld  (div_vld),
        .o_quo  (div_quo),
        .o_side (div_side)
    );

    // post-divide stage registers
    logic [63:0]        r_p, r_pa, r_a, r_pb, r_ab, r_y9, r_y8, r_pc, r_y8b;
    logic signed [48:0] r_lo9, r_lo8;
    logic [31:0]        r_hi9, r_hi8;
    logic [63:0]        r_ll;
    logic [31:0]        r_lh, r_hl;
    logic [63:0]        r_pd, r_w1f, r_w2f;
    logic [31:0]        r_q, r_qb, r_qc, r_qd;
    logic [14:0]        r_qk, r_kpa, r_kpab;
    logic [6:0]         r_r;
    logic [10:0]        r_qlo;
    logic [19:0]        r_micro;

    logic [63:0]        a, prod, sum3, pf;
    logic [46:0]        rcp;
    logic [20:0]        xb;
    logic [21:0]        rr;
    logic [7:0]         rfix;
    logic               fix;
    logic [17:0]        rem;
    logic [24:0]        mic;

    assign a    = $signed(r_p) >>> 13;
    assign prod = r_ll + {r_lh + r_hl, 32'd0};
    assign sum3 = r_pd + r_w1f + r_w2f;
    assign pf   = ($signed(sum3) >>> 8) + $signed(btpc_pkg::sext16(p7) << 4);
    assign rcp  = 47'(r_q[31:11]) * 47'(btpc_pkg::RecipM);
    assign xb   = r_qb[31:11];
    assign rr   = {1'b0, xb} - ({7'd0, r_qk} * 22'd125);
    assign fix  = (rr[7:0] >= 8'd125);
    assign rfix = rr[7:0] - 8'd125;
    assign rem  = {r_r, r_qlo};
    assign mic  = {7'd0, rem} * 25'd125;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd_post <= {r_sd_post[PostN-2:0], div_side};
            r_p       <= div_side.neg ? (64'd0 - div_quo) : div_quo;
            r_pa      <= r_p;
            r_a       <= a;
            r_lo9     <= btpc_pkg::part_lo(a, p9);
            r_hi9     <= btpc_pkg::part_hi(a, p9);
            r_lo8     <= btpc_pkg::part_lo(r_p, p8);
            r_hi8     <= btpc_pkg::part_hi(r_p, p8);
            r_pb      <= r_pa;
            r_ab      <= r_a;
            r_y9      <= btpc_pkg::join_parts(r_lo9, r_hi9);
            r_y8      <= btpc_pkg::join_parts(r_lo8, r_hi8);
            r_pc      <= r_pb;
            r_y8b     <= r_y8;
            r_ll      <= 64'(r_y9[31:0]) * 64'(r_ab[31:0]);
            r_lh      <= r_y9[31:0] * r_ab[63:32];
            r_hl      <= r_y9[63:32] * r_ab[31:0];
            r_pd      <= r_pc;
            r_w1f     <= $signed(prod) >>> 25;
            r_w2f     <= $signed(r_y8b) >>> 19;
            r_q       <= pf[31:0];
            r_qb      <= r_q;
            r_qk      <= rcp[46:32];
            r_kpa     <= r_qk + {14'd0, fix};
            r_r       <= fix ? rfix[6:0] : rr[6:0];
            r_qlo     <= r_qb[10:0];
            r_qc      <= r_qb;
            r_qd      <= r_qc;
            r_kpab    <= r_kpa;
            r_micro   <= mic[24:5];
        end
    end

    // output register
    btpc_pkg::t_side sd_last;
    logic            press_ok;
    btpc_pkg::t_status st;

    assign sd_last  = r_sd_post[PostN-1];
    assign press_ok = sd_last.kind && !sd_last.skip && !sd_last.zdiv;

    always_comb begin
        priority if (sd_last.skip) begin
            st = btpc_pkg::ST_SKIP;
        end else if (sd_last.kind && sd_last.zdiv) begin
            st = btpc_pkg::ST_ZDIV;
        end else begin
            st = btpc_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_pre  <= '0;
            r_vld_post <= '0;
            r_out_vld  <= 1'b0;
        end else if (en) begin
            r_vld_pre  <= {r_vld_pre[PreN-2:0], o_pop};
            r_vld_post <= {r_vld_post[PostN-2:0], div_vld};
            r_out_vld  <= r_vld_post[PostN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_status          <= st;
            o_temp_centi      <= sd_last.skip ? '0 : sd_last.centi;
            o_temp_milli      <= sd_last.skip ? '0 : sd_last.milli;
            o_press_q24_8     <= press_ok ? r_qd : '0;
            o_press_kpa       <= press_ok ? r_kpab : '0;
            o_press_micro_kpa <= press_ok ? r_micro : '0;
        end
    end

    assign o_valid = r_out_vld;

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == btpc_pkg::ST_SKIP) |->
        (o_temp_centi == '0 && o_press_q24_8 == '0)) else $error("skip result not cleared");
    a_zdiv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == btpc_pkg::ST_ZDIV) |->
        (o_press_q24_8 == '0 && o_press_kpa == '0)) else $error("zero divisor not cleared");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |=> $stable(r_vld_pre) && $stable(r_vld_post))
        else $error("pipeline moved under stall");

endmodule

[sim/baro_temp_press_compensation_tb.sv]
// Testbench for the barometric temperature/pressure compensation block.
`timescale 1ns / 100ps

module baro_temp_press_compensation_tb;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] centi;
        logic [31:0] milli;
        logic [31:0] q24;
        logic [14:0] kpa;
        logic [19:0] micro;
    } t_comp;

    typedef struct {
        logic        kind;
        logic [19:0] rt;
        logic [19:0] rp;
        logic        has_exp;
        t_comp       exp_res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_kind = 1'b0;
    logic [19:0] i_raw_temperature = '0;
    logic [19:0] i_raw_pressure = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic signed [31:0] o_temp_centi, o_temp_milli;
    logic [31:0] o_press_q24_8;
    logic [14:0] o_press_kpa;
    logic [19:0] o_press_micro_kpa;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    baro_temp_press_compensation dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // calibration shadow
    logic [47:0] cal_temp;
    logic [63:0] cal_plo, cal_phi;
    logic [15:0] cal_p9;

    t_comp expected_results[$];
    int    n_errors = 0;
    bit    quiet_mode = 0;   // no idling on either side
    bit    rx_hold = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sdiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] mn, md, q;
        mn = n[63] ? -n : n;
        md = d[63] ? -d : d;
        q = mn / md;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    function automatic t_comp compensate(input logic kind, input logic [19:0] rt,
                                         input logic [19:0] rp);
        t_comp r;
        logic [31:0] t1, t2, t3, v1, v2, d, tf, centi;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p, a;
        logic [31:0] q;
        r = '{default: '0};
        if (rt == btpc_pkg::SkipMark || (kind && rp == btpc_pkg::SkipMark)) begin
            r.status = btpc_pkg::ST_SKIP;
            return r;
        end
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        v1 = $signed(((32'(rt) >> 3) - (t1 << 1)) * t2) >>> 11;
        d = (32'(rt) >> 4) - t1;
        v2 = $signed(32'($signed(d * d) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        centi = $signed(tf * 32'd5 + 32'd128) >>> 8;
        r.status = btpc_pkg::ST_OK;
        r.centi = centi;
        r.milli = centi * 32'd10;
        if (!kind) return r;
        p1 = {48'd0, cal_plo[15:0]};
        p2 = btpc_pkg::sext16(cal_plo[31:16]);
        p3 = btpc_pkg::sext16(cal_plo[47:32]);
        p4 = btpc_pkg::sext16(cal_plo[63:48]);
        p5 = btpc_pkg::sext16(cal_phi[15:0]);
        p6 = btpc_pkg::sext16(cal_phi[31:16]);
        p7 = btpc_pkg::sext16(cal_phi[47:32]);
        p8 = btpc_pkg::sext16(cal_phi[63:48]);
        p9 = btpc_pkg::sext16(cal_p9);
        w1 = {{32{tf[31]}}, tf} - 64'd128000;
        w2 = w1 * w1 * p6;
        w2 = w2 + ((w1 * p5) << 17);
        w2 = w2 + (p4 << 35);
        w1 = asr64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
        w1 = asr64(((64'd1 << 47) + w1) * p1, 33);
        if (w1 == 0) begin
            r.status = btpc_pkg::ST_ZDIV;
            return r;
        end
        p = 64'd1048576 - 64'(rp);
        p = sdiv64(((p << 31) - w2) * 64'd3125, w1);
        a = asr64(p, 13);
        w1 = asr64(p9 * a * a, 25);
        w2 = asr64(p8 * p, 19);
        p = asr64(p + w1 + w2, 8) + (p7 << 4);
        q = p[31:0];
        r.q24 = q;
        r.kpa = 15'(q / 32'd256000);
        r.micro = 20'((64'(q % 32'd256000) * 64'd1000000) / 64'd256000);
        return r;
    endfunction

    task automatic reg_write(input btpc_pkg::t_reg_idx idx, input logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'(8 * idx); pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            btpc_pkg::REG_TEMP: cal_temp = val[47:0];
            btpc_pkg::REG_PLO:  cal_plo = val;
            btpc_pkg::REG_PHI:  cal_phi = val;
            btpc_pkg::REG_P9:   cal_p9 = val[15:0];
        endcase
    endtask

    task automatic send_request(input logic kind, input logic [19:0] rt,
                                input logic [19:0] rp, input bit has_exp,
                                input t_comp exp_res);
        @(negedge i_clk);
        while (!quiet_mode && $urandom_range(99) < 27) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind; i_raw_temperature <= rt; i_raw_pressure <= rp;
        if (has_exp) expected_results.push_back(exp_res);
        else expected_results.push_back(compensate(kind, rt, rp));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain_and_settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // random raw sample with extra weight on edges and the skip mark
    function automatic logic [19:0] pick_raw();
        case ($urandom_range(19))
            0: return btpc_pkg::SkipMark;
            1: return 20'h00000;
            2: return 20'hFFFFF;
            default: return 20'($urandom_range(20'h50000, 20'h90000) ^
                                ($urandom_range(9) == 0 ? $urandom : 0));
        endcase
    endfunction

    // realistic calibration with random jitter
    task automatic load_typical_cal();
        reg_write(btpc_pkg::REG_TEMP, {16'($urandom_range(30000, 32767)),
                                       16'($urandom_range(24000, 27000)),
                                       16'($urandom_range(26000, 28500))});
        reg_write(btpc_pkg::REG_PLO, {16'($urandom_range(2000, 3000)),
                                      16'(-$urandom_range(1000, 5000)),
                                      16'(-$urandom_range(10000, 11000)),
                                      16'($urandom_range(34000, 37000))});
        reg_write(btpc_pkg::REG_PHI, {16'(-$urandom_range(7000, 7500)),
                                      16'($urandom_range(12000, 15500)),
                                      16'(-$urandom_range(1, 50)),
                                      16'($urandom_range(100, 300))});
        reg_write(btpc_pkg::REG_P9, 64'(16'($urandom_range(5000, 6500))));
    endtask

    // checker with random stall and a long hold-off when requested
    always @(posedge i_clk) begin
        t_comp e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", {62'd0, o_status}, 64'd0);
            end else begin
                e = expected_results.pop_front();
                if (o_status !== e.status) report_mismatch("status", o_status, e.status);
                if (o_temp_centi !== e.centi) report_mismatch("temp_centi", o_temp_centi, e.centi);
                if (o_temp_milli !== e.milli) report_mismatch("temp_milli", o_temp_milli, e.milli);
                if (o_press_q24_8 !== e.q24) report_mismatch("press_q24_8", o_press_q24_8, e.q24);
                if (o_press_kpa !== e.kpa) report_mismatch("press_kpa", o_press_kpa, e.kpa);
                if (o_press_micro_kpa !== e.micro)
                    report_mismatch("press_micro_kpa", o_press_micro_kpa, e.micro);
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold) i_stall <= 1'b1;
        else i_stall <= !quiet_mode && ($urandom_range(99) < 27);
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        t_row  rows[$];
        t_comp z, sk, zd;
        int    hold_cnt;
        cal_temp = '0; cal_plo = '0; cal_phi = '0; cal_p9 = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        z = '{default: '0};
        sk = z; sk.status = btpc_pkg::ST_SKIP;
        zd = z; zd.status = btpc_pkg::ST_ZDIV;
        // after reset: all coefficients zero, divisor zero
        rows.push_back('{1'b0, 20'h00000, 20'h00000, 1'b1, z});
        rows.push_back('{1'b0, 20'hFFFFF, 20'hFFFFF, 1'b1, z});
        rows.push_back('{1'b1, 20'h12345, 20'h54321, 1'b1, zd});
        rows.push_back('{1'b1, 20'hFFFFF, 20'h00000, 1'b1, zd});
        rows.push_back('{1'b0, btpc_pkg::SkipMark, 20'h00000, 1'b1, sk});
        rows.push_back('{1'b1, btpc_pkg::SkipMark, 20'h12345, 1'b1, sk});
        rows.push_back('{1'b1, 20'h6A000, btpc_pkg::SkipMark, 1'b1, sk});
        rows.push_back('{1'b0, 20'h6A000, btpc_pkg::SkipMark, 1'b0, z});  // pressure skip ignored
        foreach (rows[k]) send_request(rows[k].kind, rows[k].rt, rows[k].rp,
                                       rows[k].has_exp, rows[k].exp_res);
        drain_and_settle();

        // typical calibration, predictor-checked edge rows
        load_typical_cal();
        rows.delete();
        rows.push_back('{1'b0, 20'h7E000, 20'h0, 1'b0, z});
        rows.push_back('{1'b1, 20'h7E000, 20'h65000, 1'b0, z});
        rows.push_back('{1'b1, 20'h00000, 20'h00000, 1'b0, z});
        rows.push_back('{1'b1, 20'hFFFFF, 20'hFFFFF, 1'b0, z});
        rows.push_back('{1'b1, 20'h7FFFF, 20'h80001, 1'b0, z});
        rows.push_back('{1'b0, 20'h80001, 20'h7FFFF, 1'b0, z});
        foreach (rows[k]) send_request(rows[k].kind, rows[k].rt, rows[k].rp, 1'b0, z);
        drain_and_settle();

        // extreme calibration settings
        reg_write(btpc_pkg::REG_TEMP, 64'h0000_FFFF_FFFF_FFFF);
        reg_write(btpc_pkg::REG_PLO, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(btpc_pkg::REG_PHI, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(btpc_pkg::REG_P9, 64'h0000_0000_0000_FFFF);
        for (int k = 0; k < 6; k++)
            send_request(k[0], 20'($urandom), 20'($urandom), 1'b0, z);
        drain_and_settle();
        reg_write(btpc_pkg::REG_TEMP, 64'h0000_7FFF_8000_FFFF);
        reg_write(btpc_pkg::REG_PLO, 64'h8000_7FFF_8000_FFFF);
        reg_write(btpc_pkg::REG_PHI, 64'h7FFF_8000_7FFF_8000);
        reg_write(btpc_pkg::REG_P9, 64'h0000_0000_0000_8000);
        for (int k = 0; k < 6; k++)
            send_request(k[0], 20'($urandom), 20'($urandom), 1'b0, z);
        drain_and_settle();

        // random phases: mostly realistic calibration, some fully random
        for (int ph = 0; ph < 8; ph++) begin
            if (ph % 3 == 2) begin
                reg_write(btpc_pkg::REG_TEMP, {$urandom, $urandom});
                reg_write(btpc_pkg::REG_PLO, {$urandom, $urandom});
                reg_write(btpc_pkg::REG_PHI, {$urandom, $urandom});
                reg_write(btpc_pkg::REG_P9, 64'($urandom));
            end else begin
                load_typical_cal();
            end
            quiet_mode = (ph == 4);
            if (ph == 2) begin
                // long receiver hold-off while the sender keeps going
                fork
                    begin
                        rx_hold = 1;
                        hold_cnt = 0;
                        while (hold_cnt < 300) begin
                            @(posedge i_clk);
                            hold_cnt++;
                        end
                        rx_hold = 0;
                    end
                join_none
            end
            for (int k = 0; k < 100; k++)
                send_request($urandom_range(1), pick_raw(), pick_raw(), 1'b0, z);
            quiet_mode = 0;
            drain_and_settle();
        end

        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/btpc_pkg.sv
hw/rtl/btpc_front.sv
hw/rtl/btpc_queue.sv
hw/rtl/btpc_div.sv
hw/rtl/btpc_back.sv
hw/rtl/baro_temp_press_compensation.sv
sim/baro_temp_press_compensation_tb.sv
